### rtl/max_heap_priority_queue_core_defines.svh
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MHPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhpq check failed");

// next-cycle implication, sampled on clk, off during reset
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhpq check failed");

`endif

### rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int KEY_W = 32;
    localparam int COUNT_OUT_W = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_EMPTY = '1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UP_CMP = 5'b00010,
        ST_UP_FIN = 5'b00100,
        ST_POP_LD = 5'b01000,
        ST_DN_CMP = 5'b10000
    } state_t;

endpackage

### rtl/max_heap_priority_queue_core.sv
// insert into an empty heap completes from idle; other inserts sift up in ST_UP_CMP,
// and ST_UP_FIN at the root; a pop that empties the heap completes from idle,
// else ST_POP_LD, ST_DN_CMP sift the last entry down; one item in flight, one level per
// cycle through the single write port of the heap store; done pulses one cycle
// reset clears the entry count and control; store contents stay undefined, no clear pass
`timescale 1ns / 1ps
module max_heap_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   value,
    output logic                                done,
    output logic signed [mhpq_pkg::KEY_W-1:0]   top_value,
    output logic                                empty_res,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0]    count,
    output logic                                overflow
);
    import mhpq_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = AW + 2;

    logic signed [KEY_W-1:0] heap_mem [CAPACITY];

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] top_reg, top_next;
    logic                    ovf_reg, ovf_next;
    logic                    done_reg, done_next;
    logic signed [KEY_W-1:0] rd_a_reg, rd_b_reg;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic [AW-1:0]           rd_addr_a, rd_addr_b;

    logic [AW-1:0]           par;
    logic [CW-1:0]           lc, rc, nl, nr;
    logic                    l_ok, r_ok, moved;
    logic [AW-1:0]           best_idx;
    logic signed [KEY_W-1:0] best_val;

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        logic [AW-1:0] d;
        d = p - 1'b1;
        return d >> 1;
    endfunction

    // heap store: one write, two registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    // sift-down child selection
    always_comb
    begin
        par = parent_of(pos_reg);
        lc  = {1'b0, pos_reg, 1'b1};
        rc  = lc + 1'b1;
        l_ok = lc < CW'(count_reg);
        r_ok = rc < CW'(count_reg);
        best_idx = pos_reg;
        best_val = key_reg;
        moved    = 1'b0;
        if (l_ok && (rd_a_reg > best_val))
        begin
            best_idx = lc[AW-1:0];
            best_val = rd_a_reg;
            moved    = 1'b1;
        end
        if (r_ok && (rd_b_reg > best_val))
        begin
            best_idx = rc[AW-1:0];
            best_val = rd_b_reg;
            moved    = 1'b1;
        end
        nl = {1'b0, best_idx, 1'b1};
        nr = nl + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = key_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ovf_next = 1'b0;
                    if (func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            ovf_next  = 1'b1;
                            done_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = value;
                            top_next   = value;
                            count_next = count_reg + 1'b1;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            key_next   = value;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                            rd_addr_a  = parent_of(count_reg[AW-1:0]);
                            state_next = ST_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg <= CNT_W'(1))
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            rd_addr_a  = AW'(count_reg - 1'b1);
                            state_next = ST_POP_LD;
                        end
                    end
                end
            end
            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (key_reg > rd_a_reg)
                begin
                    wr_data   = rd_a_reg;
                    pos_next  = par;
                    rd_addr_a = parent_of(par);
                    if (par == '0)
                    begin
                        state_next = ST_UP_FIN;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_UP_FIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                top_next   = key_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_POP_LD:
            begin
                key_next   = rd_a_reg;
                pos_next   = '0;
                rd_addr_a  = AW'(1);
                rd_addr_b  = AW'(2);
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = best_val;
                if (pos_reg == '0)
                begin
                    top_next = best_val;
                end
                if (moved)
                begin
                    pos_next  = best_idx;
                    rd_addr_a = nl[AW-1:0];
                    rd_addr_b = nr[AW-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        top_reg <= top_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign empty_res = (count_reg == '0);
    assign top_value = empty_res ? KEY_EMPTY : top_reg;
    assign count     = COUNT_OUT_W'(count_reg);
    assign overflow  = ovf_reg;

endmodule

### rtl/mhpq_checker.sv
`timescale 1ns / 1ps
`include "max_heap_priority_queue_core_defines.svh"
module mhpq_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic signed [mhpq_pkg::KEY_W-1:0]   top_value,
    input logic                                empty_res,
    input logic [mhpq_pkg::COUNT_OUT_W-1:0]    count,
    input logic                                overflow
);
    import mhpq_pkg::*;

    // empty flag agrees with the count on every transfer
    `MHPQ_ASSERT_NOW(a_empty_count, done, empty_res == (count == '0))
    // an empty heap reports the empty key
    `MHPQ_ASSERT_NOW(a_empty_key, done && empty_res, top_value == KEY_EMPTY)
    // a dropped insert only happens at full capacity
    `MHPQ_ASSERT_NOW(a_ovf_full, done && overflow, count == COUNT_OUT_W'(CAPACITY))
    // every accepted item either completes at once or holds the block busy
    `MHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
    // no result appears without work
    `MHPQ_ASSERT_NEXT(a_no_spurious, !busy && !start, !done)

endmodule

bind max_heap_priority_queue_core mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
